// File: src/ipipenc_pkg.sv
// Shared types and constants for the IPv4-in-IPv4 tunnel encapsulator.
// No dependencies; imported by every module of the block.
package ipipenc_pkg;

   localparam int MAX_FRAME_LEN   = 16383;
   localparam int HOLD_BYTES      = 34;
   localparam int ETH_BYTES       = 14;
   localparam int TUNNEL_BYTES    = 54;
   localparam int QUEUE_DEPTH_DEF = 4;

   localparam logic [31:0] RST_RANGE_LOW  = 32'hC0A8_0000;
   localparam logic [31:0] RST_RANGE_HIGH = 32'hC0A8_FFFF;
   localparam logic [31:0] RST_TUN_SRC    = 32'hC0A8_C901;
   localparam logic [31:0] RST_TUN_DST    = 32'hC0A8_CA02;

   localparam logic [15:0] ETYPE_IPV4 = 16'h0800;
   localparam logic [15:0] DF_FLAG    = 16'h4000;
   localparam logic [7:0]  OUTER_TTL  = 8'd64;
   localparam logic [7:0]  PROTO_IPIP = 8'd4;
   localparam logic [7:0]  VER_IHL    = 8'h45;

   // register indexes on the csr port
   localparam logic [2:0] REG_RANGE_LOW  = 3'd0;
   localparam logic [2:0] REG_RANGE_HIGH = 3'd1;
   localparam logic [2:0] REG_TUN_SRC    = 3'd2;
   localparam logic [2:0] REG_TUN_DST    = 3'd3;
   localparam logic [2:0] REG_HOP_SMAC   = 3'd4;
   localparam logic [2:0] REG_HOP_DMAC   = 3'd5;
   localparam logic [2:0] REG_ROUTE_OK   = 3'd6;

   typedef struct packed {
      logic [31:0] range_low;
      logic [31:0] range_high;
      logic [31:0] tunnel_source;
      logic [31:0] tunnel_destination;
      logic [47:0] hop_source_mac;
      logic [47:0] hop_dest_mac;
      logic        route_ok;
   } cfg_type;

   // work word kinds passed from front to back
   typedef enum logic [1:0] {
      ENT_STORE  = 2'd0,
      ENT_DATA   = 2'd1,
      ENT_FLUSH  = 2'd2,
      ENT_TUNNEL = 2'd3
   } ent_kind_type;

   typedef struct packed {
      ent_kind_type kind;
      logic [7:0]   data;
      logic         last;
      logic         verdict;
      logic [5:0]   pos;      // buffer slot of data; for flush also the final slot
      logic [13:0]  held;     // clamped frame length
   } entry_type;

endpackage

// File: src/ipipenc_front.sv
// Front end: accepts frame bytes, tracks frame position and makes the tunnel decision.
// Depends on ipipenc_pkg; feeds work words into ipipenc_queue.
module ipipenc_front
   import ipipenc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  cfg_type     cfg,
   input  logic        req_valid,
   input  logic        queue_full,
   input  logic [7:0]  req_in_byte,
   input  logic        req_in_last,
   input  logic [13:0] req_frame_length,
   output logic        req_stall,
   output logic        push,
   output entry_type   push_entry
);

   typedef enum logic [3:0] {
      MODE_COLLECT = 4'b0001,
      MODE_PASS    = 4'b0010,
      MODE_TUNNEL  = 4'b0100,
      MODE_DROP    = 4'b1000
   } mode_type;

   localparam logic [5:0] DECIDE_POS = 6'(HOLD_BYTES - 1);
   localparam logic [5:0] SAT_POS    = 6'(HOLD_BYTES);

   mode_type    mode_ff, mode_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic [13:0] held_ff, held_in;
   logic [7:0]  b12_ff, b13_ff, b30_ff, b31_ff, b32_ff;
   logic        accept;
   logic [31:0] daddr;
   logic        is_ip, hit;

   assign req_stall = queue_full;
   assign accept    = req_valid && !queue_full;
   assign daddr     = {b30_ff, b31_ff, b32_ff, req_in_byte};
   assign is_ip     = ({b12_ff, b13_ff} == ETYPE_IPV4);
   assign hit       = is_ip && (daddr >= cfg.range_low) && (daddr <= cfg.range_high);

   always_comb begin
      mode_in            = mode_ff;
      cnt_in             = cnt_ff;
      held_in            = held_ff;
      push               = 1'b0;
      push_entry.kind    = ENT_STORE;
      push_entry.data    = req_in_byte;
      push_entry.last    = req_in_last;
      push_entry.verdict = 1'b0;
      push_entry.pos     = cnt_ff;
      push_entry.held    = held_ff;
      if (accept) begin
         if (cnt_ff == '0) begin
            held_in = (17'(req_frame_length) > 17'(MAX_FRAME_LEN)) ?
                      14'(MAX_FRAME_LEN) : req_frame_length;
         end
         case (mode_ff)
            MODE_COLLECT: begin
               if (cnt_ff == DECIDE_POS) begin
                  if (!hit) begin
                     push            = 1'b1;
                     push_entry.kind = ENT_FLUSH;
                     mode_in         = MODE_PASS;
                  end else if (cfg.route_ok) begin
                     push               = 1'b1;
                     push_entry.kind    = ENT_TUNNEL;
                     push_entry.verdict = 1'b1;
                     mode_in            = MODE_TUNNEL;
                  end else begin
                     mode_in = MODE_DROP;
                  end
               end else begin
                  push            = 1'b1;
                  push_entry.kind = req_in_last ? ENT_FLUSH : ENT_STORE;
               end
            end
            MODE_PASS: begin
               push            = 1'b1;
               push_entry.kind = ENT_DATA;
            end
            MODE_TUNNEL: begin
               push               = 1'b1;
               push_entry.kind    = ENT_DATA;
               push_entry.verdict = 1'b1;
            end
            default: begin
               push = 1'b0;
            end
         endcase
         if (req_in_last) begin
            mode_in = MODE_COLLECT;
            cnt_in  = '0;
         end else if (cnt_ff < SAT_POS) begin
            cnt_in = cnt_ff + 6'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_COLLECT;
         cnt_ff  <= '0;
         held_ff <= '0;
      end else begin
         mode_ff <= mode_in;
         cnt_ff  <= cnt_in;
         held_ff <= held_in;
      end
   end

   // bytes the decision needs: EtherType and the first three address bytes
   always_ff @(posedge clock) begin
      if (accept && mode_ff == MODE_COLLECT) begin
         if (cnt_ff == 6'd12) b12_ff <= req_in_byte;
         if (cnt_ff == 6'd13) b13_ff <= req_in_byte;
         if (cnt_ff == 6'd30) b30_ff <= req_in_byte;
         if (cnt_ff == 6'd31) b31_ff <= req_in_byte;
         if (cnt_ff == 6'd32) b32_ff <= req_in_byte;
      end
   end

endmodule

// File: src/ipipenc_queue.sv
// Short register queue of work words between front and back.
// Depends on ipipenc_pkg for the word type.
module ipipenc_queue
   import ipipenc_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  entry_type push_entry,
   input  logic      pop,
   output logic      full,
   output logic      head_valid,
   output entry_type head
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);

   entry_type         slot_ff [DEPTH];
   logic [PW-1:0]     wr_ff, wr_in, rd_ff, rd_in;
   logic [CW-1:0]     count_ff, count_in;
   logic              do_push, do_pop;

   assign full       = (count_ff == CW'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head       = slot_ff[rd_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_in    = wr_ff;
      rd_in    = rd_ff;
      count_in = count_ff;
      if (do_push) wr_in = (wr_ff == LAST_PTR) ? '0 : wr_ff + PW'(1);
      if (do_pop)  rd_in = (rd_ff == LAST_PTR) ? '0 : rd_ff + PW'(1);
      if (do_push && !do_pop) count_in = count_ff + CW'(1);
      else if (!do_push && do_pop) count_in = count_ff - CW'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) slot_ff[wr_ff] <= push_entry;
   end

endmodule

// File: src/ipipenc_back.sv
// Back end: holds the first 34 frame bytes, sequences flushes and the tunnel header,
// computes the outer checksum and drives the rsp output register. Depends on ipipenc_pkg.
module ipipenc_back
   import ipipenc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  cfg_type     cfg,
   input  logic        head_valid,
   input  entry_type   head,
   output logic        pop,
   input  logic        rsp_stall,
   output logic        rsp_valid,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_out_last,
   output logic        rsp_verdict
);

   typedef enum logic [2:0] {
      SEQ_IDLE   = 3'b001,
      SEQ_FLUSH  = 3'b010,
      SEQ_TUNNEL = 3'b100
   } seq_type;

   localparam logic [5:0] HDR_END  = 6'(HOLD_BYTES);
   localparam logic [5:0] ETH_END  = 6'(ETH_BYTES);
   localparam logic [5:0] TUN_LAST = 6'(TUNNEL_BYTES - 1);
   localparam logic [5:0] HDR_TOP  = 6'(HOLD_BYTES - 1);
   localparam logic [19:0] SUM_CONST =
      20'({VER_IHL, 8'h00}) + 20'(DF_FLAG) + 20'({OUTER_TTL, PROTO_IPIP});

   logic [7:0]   hb_ff [HOLD_BYTES];
   seq_type      seq_ff, seq_in;
   logic [5:0]   step_ff, step_in, end_ff, end_in;
   logic         last_ff, last_in;
   logic [15:0]  tot_ff, tot_in;
   logic [19:0]  sum_ff, sum_in, base_ff;
   logic         out_valid_ff, out_valid_in, out_last_ff, out_last_in;
   logic         out_verdict_ff, out_verdict_in;
   logic [7:0]   out_byte_ff, out_byte_in;
   logic         out_free, store_en, shift_en, emit;
   logic [15:0]  cksum;
   logic [271:0] hdr_vec;
   logic [5:0]   hdr_sel;
   logic [7:0]   seq_byte;

   assign out_free = !out_valid_ff || !rsp_stall;
   assign cksum    = ~sum_ff[15:0];
   assign hdr_vec  = {cfg.hop_dest_mac, cfg.hop_source_mac, ETYPE_IPV4,
                      VER_IHL, 8'h00, tot_ff, 16'h0000, DF_FLAG, OUTER_TTL, PROTO_IPIP,
                      cksum, cfg.tunnel_source, cfg.tunnel_destination};
   assign hdr_sel  = HDR_TOP - step_ff;
   assign seq_byte = (seq_ff == SEQ_TUNNEL && step_ff < HDR_END) ?
                     hdr_vec[{hdr_sel, 3'b000} +: 8] : hb_ff[0];

   always_comb begin
      seq_in         = seq_ff;
      step_in        = step_ff;
      end_in         = end_ff;
      last_in        = last_ff;
      tot_in         = tot_ff;
      // fold the carry every cycle; settles long before the checksum bytes go out
      sum_in         = {4'h0, sum_ff[15:0]} + {16'h0000, sum_ff[19:16]};
      pop            = 1'b0;
      store_en       = 1'b0;
      shift_en       = 1'b0;
      emit           = 1'b0;
      out_byte_in    = out_byte_ff;
      out_last_in    = out_last_ff;
      out_verdict_in = out_verdict_ff;
      case (seq_ff)
         SEQ_IDLE: begin
            if (head_valid) begin
               case (head.kind)
                  ENT_STORE: begin
                     pop      = 1'b1;
                     store_en = 1'b1;
                  end
                  ENT_DATA: begin
                     if (out_free) begin
                        pop            = 1'b1;
                        emit           = 1'b1;
                        out_byte_in    = head.data;
                        out_last_in    = head.last;
                        out_verdict_in = head.verdict;
                     end
                  end
                  ENT_FLUSH: begin
                     pop      = 1'b1;
                     store_en = 1'b1;
                     seq_in   = SEQ_FLUSH;
                     step_in  = '0;
                     end_in   = head.pos;
                     last_in  = head.last;
                  end
                  default: begin
                     pop      = 1'b1;
                     store_en = 1'b1;
                     seq_in   = SEQ_TUNNEL;
                     step_in  = '0;
                     end_in   = TUN_LAST;
                     last_in  = head.last;
                     tot_in   = 16'(head.held) + 16'd6;
                     sum_in   = base_ff + 20'(16'(head.held) + 16'd6);
                  end
               endcase
            end
         end
         default: begin
            if (out_free) begin
               emit           = 1'b1;
               out_byte_in    = seq_byte;
               out_last_in    = last_ff && (step_ff == end_ff);
               out_verdict_in = (seq_ff == SEQ_TUNNEL);
               // tunnel drops the old Ethernet header and pauses during the outer IP header
               shift_en       = (seq_ff == SEQ_FLUSH) || (step_ff < ETH_END) ||
                                (step_ff >= HDR_END);
               step_in        = step_ff + 6'd1;
               if (step_ff == end_ff) seq_in = SEQ_IDLE;
            end
         end
      endcase
      if (emit) out_valid_in = 1'b1;
      else      out_valid_in = out_valid_ff && rsp_stall;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff       <= SEQ_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         seq_ff       <= seq_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff        <= step_in;
      end_ff         <= end_in;
      last_ff        <= last_in;
      tot_ff         <= tot_in;
      sum_ff         <= sum_in;
      base_ff        <= SUM_CONST + 20'(cfg.tunnel_source[31:16]) +
                        20'(cfg.tunnel_source[15:0]) + 20'(cfg.tunnel_destination[31:16]) +
                        20'(cfg.tunnel_destination[15:0]);
      out_byte_ff    <= out_byte_in;
      out_last_ff    <= out_last_in;
      out_verdict_ff <= out_verdict_in;
   end

   always_ff @(posedge clock) begin
      if (store_en) begin
         hb_ff[head.pos] <= head.data;
      end else if (shift_en) begin
         for (int i = 0; i < HOLD_BYTES - 1; i++) hb_ff[i] <= hb_ff[i + 1];
      end
   end

   assign rsp_valid    = out_valid_ff;
   assign rsp_out_byte = out_byte_ff;
   assign rsp_out_last = out_last_ff;
   assign rsp_verdict  = out_verdict_ff;

endmodule

// File: src/ipip_tunnel_encapsulator.sv
// Top level of the IPv4-in-IPv4 tunnel encapsulator: csr registers, front, queue, back.
// Depends on ipipenc_pkg, ipipenc_front, ipipenc_queue, ipipenc_back.
//
//  channel  ports                                         handshake
//  -------  --------------------------------------------  ------------------------
//  req      req_in_byte, req_in_last, req_frame_length    req_valid / req_stall
//  rsp      rsp_out_byte, rsp_out_last, rsp_verdict       rsp_valid / rsp_stall
//  csr      csr_index, csr_wdata                          csr_we, no wait
//
// One byte per cycle in and out once a frame is decided, while no stall holds the flow.
// The 34th byte of a frame yields 34 bytes (pass) or 54 bytes (tunnel) from the back-end
// sequencer, one per cycle while rsp_stall is low; the work queue absorbs input meanwhile,
// then req_stall rises. Each accepted byte is registered in a queue slot, then in the rsp
// output register. Reset is synchronous; there is no clearing pass.
module ipip_tunnel_encapsulator
   import ipipenc_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_in_byte,
   input  logic        req_in_last,
   input  logic [13:0] req_frame_length,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_out_last,
   output logic        rsp_verdict,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [47:0] csr_wdata
);

   cfg_type   cfg_ff, cfg_in;
   logic      push, pop, queue_full, head_valid;
   entry_type push_entry, head;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            REG_RANGE_LOW:  cfg_in.range_low          = csr_wdata[31:0];
            REG_RANGE_HIGH: cfg_in.range_high         = csr_wdata[31:0];
            REG_TUN_SRC:    cfg_in.tunnel_source      = csr_wdata[31:0];
            REG_TUN_DST:    cfg_in.tunnel_destination = csr_wdata[31:0];
            REG_HOP_SMAC:   cfg_in.hop_source_mac     = csr_wdata;
            REG_HOP_DMAC:   cfg_in.hop_dest_mac       = csr_wdata;
            REG_ROUTE_OK:   cfg_in.route_ok           = csr_wdata[0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.range_low          <= RST_RANGE_LOW;
         cfg_ff.range_high         <= RST_RANGE_HIGH;
         cfg_ff.tunnel_source      <= RST_TUN_SRC;
         cfg_ff.tunnel_destination <= RST_TUN_DST;
         cfg_ff.hop_source_mac     <= '0;
         cfg_ff.hop_dest_mac       <= '0;
         cfg_ff.route_ok           <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   ipipenc_front u_front (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg_ff),
      .req_valid        (req_valid),
      .queue_full       (queue_full),
      .req_in_byte      (req_in_byte),
      .req_in_last      (req_in_last),
      .req_frame_length (req_frame_length),
      .req_stall        (req_stall),
      .push             (push),
      .push_entry       (push_entry)
   );

   ipipenc_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .full       (queue_full),
      .head_valid (head_valid),
      .head       (head)
   );

   ipipenc_back u_back (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg_ff),
      .head_valid   (head_valid),
      .head         (head),
      .pop          (pop),
      .rsp_stall    (rsp_stall),
      .rsp_valid    (rsp_valid),
      .rsp_out_byte (rsp_out_byte),
      .rsp_out_last (rsp_out_last),
      .rsp_verdict  (rsp_verdict)
   );

endmodule

// File: src/ipipenc_checker.sv
// Port-level checks for ipip_tunnel_encapsulator, bound to the top level.
// Sees only the top-level ports.
module ipipenc_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_stall,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [7:0] rsp_out_byte,
   input logic       rsp_out_last,
   input logic       rsp_verdict
);

   // reset leaves nothing pending on either side
   a_reset_clean: assert property (@(posedge clock)
      reset |=> (!rsp_valid && !req_stall))
      else $error("output valid or input stall after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=>
         (rsp_valid && $stable(rsp_out_byte) && $stable(rsp_out_last) &&
          $stable(rsp_verdict)))
      else $error("stalled rsp word changed");

   // back-to-back words of one frame carry the same verdict
   a_verdict_steady: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && !rsp_out_last) ##1 (rsp_valid && !rsp_stall) |->
         (rsp_verdict == $past(rsp_verdict)))
      else $error("verdict changed inside a frame");

   // a passed frame never turns tunneled partway through
   a_tunnel_not_short: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && !rsp_out_last && !rsp_verdict) ##1
         (rsp_valid && !rsp_stall) |-> !rsp_verdict)
      else $error("verdict rose inside a passed frame");

endmodule

bind ipip_tunnel_encapsulator ipipenc_checker u_checker (.*);
